FILE: src/ibp_pkg.sv
// Package for the indirect block path resolver: widths, codes, shared types.
// Used by every module under src; no dependencies of its own.
package ibp_pkg;

  // Field widths
  localparam int unsigned BN_W   = 44;  // logical block number
  localparam int unsigned OFF_W  = 14;  // pointer offset
  localparam int unsigned LG_W   = 4;   // log2 pointers-per-block register
  localparam int unsigned ST_W   = 2;   // status code
  localparam int unsigned DP_W   = 46;  // internal datapath, holds |bn| plus margin
  localparam int unsigned LBC_W  = 6;   // accumulated shift, up to 3 * 14
  localparam int unsigned LVL_W  = 2;   // indirection level index

  // Inode layout
  localparam int unsigned DIRECT_POINTERS = 12;
  localparam int unsigned LG_MAX          = 14;
  localparam int unsigned LG_RESET        = 10;
  localparam logic [LVL_W-1:0] LAST_LEVEL = 2'd2;  // triple indirect

  typedef enum logic [ST_W-1:0] {
    ST_PATH   = 2'd0,
    ST_DIRECT = 2'd1,
    ST_RANGE  = 2'd2
  } status_e;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_ABS    = 8'b0000_0010,
    S_BIAS   = 8'b0000_0100,
    S_SEARCH = 8'b0000_1000,
    S_BASE1  = 8'b0001_0000,
    S_BASE2  = 8'b0010_0000,
    S_EMIT0  = 8'b0100_0000,
    S_LOOP   = 8'b1000_0000
  } state_e;

  // Operands for the shared adder: sum = a + b + cin
  typedef struct packed {
    logic [DP_W-1:0] a;
    logic [DP_W-1:0] b;
    logic [1:0]      cin;
  } alu_req_t;

endpackage

FILE: src/indirect_block_path.sv
// Indirect block path resolver for a classic inode layout: 12 direct
// pointers, then single, double and triple indirect levels. A request is
// taken when start is high and busy is low; the block then stays busy until
// its final result is out. Results come one per strobe of result_valid_o and
// cannot be held off; last_o marks the final one. A direct block gives a single
// result, as does a block beyond the triple indirect level. A path of depth d
// (1 to 3) gives up to d + 1 entries. Every step (magnitude, level search,
// base number, per-level update) goes through one shared 46-bit adder. The
// entry of the inode comes first, then, after a gap, one entry per cycle.
// The pointers-per-block register is written with cfg_we_i; the user must
// write it only while idle, which the block does not enforce. Values above
// 14 act as 14.
// Depends on ibp_pkg, ibp_alu and ibp_core.
module indirect_block_path (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ibp_pkg::BN_W-1:0]     block_number_i,
  input  logic                                cfg_we_i,
  input  logic [ibp_pkg::LG_W-1:0]            cfg_wdata_i,
  output logic                                result_valid_o,
  output logic [ibp_pkg::ST_W-1:0]            status_o,
  output logic signed [ibp_pkg::BN_W-1:0]     level_block_o,
  output logic [ibp_pkg::OFF_W-1:0]           level_offset_o,
  output logic                                last_o
);

  logic [ibp_pkg::LG_W-1:0]  lg_cfg_q;
  logic [ibp_pkg::LG_W-1:0]  lg_eff;
  ibp_pkg::alu_req_t         alu_req;
  logic [ibp_pkg::DP_W-1:0]  alu_sum;
  logic [ibp_pkg::BN_W-1:0]  res_blk;

  // Pointers-per-block register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_cfg_q <= ibp_pkg::LG_W'(ibp_pkg::LG_RESET);
    end else if (cfg_we_i) begin
      lg_cfg_q <= cfg_wdata_i;
    end
  end

  // Clamp to the largest supported block
  assign lg_eff = (lg_cfg_q > ibp_pkg::LG_W'(ibp_pkg::LG_MAX)) ?
                  ibp_pkg::LG_W'(ibp_pkg::LG_MAX) : lg_cfg_q;

  ibp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .block_number_i (block_number_i),
    .lg_i           (lg_eff),
    .busy_o         (busy),
    .alu_req_o      (alu_req),
    .alu_sum_i      (alu_sum),
    .res_vld_o      (result_valid_o),
    .res_status_o   (status_o),
    .res_blk_o      (res_blk),
    .res_off_o      (level_offset_o),
    .res_last_o     (last_o)
  );

  ibp_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  assign level_block_o = $signed(res_blk);

endmodule

FILE: src/ibp_alu.sv
// Shared adder of the path resolver: one wide add with a small carry-in.
// Depends on ibp_pkg.
module ibp_alu (
  input  ibp_pkg::alu_req_t            req_i,
  output logic [ibp_pkg::DP_W-1:0]     sum_o
);

  // Subtraction is done by the sequencer as a + ~b + 1
  assign sum_o = req_i.a + req_i.b + ibp_pkg::DP_W'(req_i.cin);

endmodule

FILE: src/ibp_core.sv
// Sequencer and datapath registers of the path resolver.
// Depends on ibp_pkg; drives the shared adder ibp_alu through a request struct.
module ibp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ibp_pkg::BN_W-1:0]      block_number_i,
  input  logic [ibp_pkg::LG_W-1:0]      lg_i,
  output logic                          busy_o,
  output ibp_pkg::alu_req_t             alu_req_o,
  input  logic [ibp_pkg::DP_W-1:0]      alu_sum_i,
  output logic                          res_vld_o,
  output logic [ibp_pkg::ST_W-1:0]      res_status_o,
  output logic [ibp_pkg::BN_W-1:0]      res_blk_o,
  output logic [ibp_pkg::OFF_W-1:0]     res_off_o,
  output logic                          res_last_o
);

  localparam int unsigned DP_W  = ibp_pkg::DP_W;
  localparam int unsigned BN_W  = ibp_pkg::BN_W;
  localparam int unsigned OFF_W = ibp_pkg::OFF_W;

  // Control state
  ibp_pkg::state_e state_q, state_d;
  logic            hold_vld_q, hold_vld_d;
  logic            out_vld_q, out_vld_d;

  // Datapath registers
  logic [BN_W-1:0]           raw_q, raw_d;
  logic [ibp_pkg::LG_W-1:0]  lg_q, lg_d;
  logic [DP_W-1:0]           mag_q, mag_d;     // |bn|, later reused for the base sum
  logic [DP_W-1:0]           bn_q, bn_d;       // remaining block index
  logic [DP_W-1:0]           metal_q, metal_d; // metadata block number
  logic [ibp_pkg::LBC_W-1:0] lbc_q, lbc_d;
  logic [ibp_pkg::LVL_W-1:0] lvl_q, lvl_d;
  logic [ibp_pkg::LVL_W-1:0] rem_q, rem_d;     // path entries left to form
  logic [DP_W-1:0]           hold_blk_q, hold_blk_d;
  logic [OFF_W-1:0]          hold_off_q, hold_off_d;

  // Output registers
  logic [ibp_pkg::ST_W-1:0]  out_st_q, out_st_d;
  logic [BN_W-1:0]           out_blk_q, out_blk_d;
  logic [OFF_W-1:0]          out_off_q, out_off_d;
  logic                      out_last_q, out_last_d;

  // Helpers
  logic [DP_W-1:0]           real_bn;
  logic [ibp_pkg::LBC_W-1:0] lbc_up, lbc_dn;
  logic [DP_W-1:0]           blkcnt;
  logic [OFF_W-1:0]          off_mask, off_val;
  logic [DP_W-1:0]           bn_shr, off_shl;
  logic                      sum_neg, metal_hit, fin;

  assign real_bn  = {{(DP_W-BN_W){raw_q[BN_W-1]}}, raw_q};
  assign lbc_up   = lbc_q + ibp_pkg::LBC_W'(lg_q);
  assign lbc_dn   = lbc_q - ibp_pkg::LBC_W'(lg_q);
  assign blkcnt   = DP_W'(1) << lbc_up;
  assign off_mask = (OFF_W'(1) << lg_q) - OFF_W'(1);
  assign bn_shr   = bn_q >> lbc_dn;
  assign off_val  = bn_shr[OFF_W-1:0] & off_mask;
  assign off_shl  = DP_W'(off_val) << lbc_dn;
  assign sum_neg  = alu_sum_i[DP_W-1];
  assign metal_hit = (metal_q == real_bn);

  // Operand select for the shared adder
  always_comb begin
    alu_req_o = '0;
    unique case (state_q)
      ibp_pkg::S_ABS: begin
        if (raw_q[BN_W-1]) begin
          alu_req_o.b   = ~real_bn;
          alu_req_o.cin = 2'd1;
        end else begin
          alu_req_o.a = real_bn;
        end
      end
      ibp_pkg::S_BIAS: begin
        alu_req_o.a   = mag_q;
        alu_req_o.b   = ~DP_W'(ibp_pkg::DIRECT_POINTERS);
        alu_req_o.cin = 2'd1;
      end
      ibp_pkg::S_SEARCH: begin
        alu_req_o.a   = bn_q;
        alu_req_o.b   = ~blkcnt;
        alu_req_o.cin = 2'd1;
      end
      ibp_pkg::S_BASE1: begin
        // mag - bn + level
        alu_req_o.a   = mag_q;
        alu_req_o.b   = ~bn_q;
        alu_req_o.cin = lvl_q + 2'd1;
      end
      ibp_pkg::S_BASE2: begin
        // negate
        alu_req_o.b   = ~mag_q;
        alu_req_o.cin = 2'd1;
      end
      ibp_pkg::S_LOOP: begin
        // metal + 1 - (off << lbc)
        alu_req_o.a   = metal_q;
        alu_req_o.b   = ~off_shl;
        alu_req_o.cin = 2'd2;
      end
      default: alu_req_o = '0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    hold_vld_d = hold_vld_q;
    out_vld_d  = 1'b0;
    raw_d      = raw_q;
    lg_d       = lg_q;
    mag_d      = mag_q;
    bn_d       = bn_q;
    metal_d    = metal_q;
    lbc_d      = lbc_q;
    lvl_d      = lvl_q;
    rem_d      = rem_q;
    hold_blk_d = hold_blk_q;
    hold_off_d = hold_off_q;
    out_st_d   = out_st_q;
    out_blk_d  = out_blk_q;
    out_off_d  = out_off_q;
    out_last_d = out_last_q;
    fin        = 1'b0;

    unique case (state_q)
      ibp_pkg::S_IDLE: begin
        if (start_i) begin
          raw_d   = block_number_i;
          lg_d    = lg_i;
          lbc_d   = '0;
          lvl_d   = '0;
          state_d = ibp_pkg::S_ABS;
        end
      end
      ibp_pkg::S_ABS: begin
        mag_d   = alu_sum_i;
        state_d = ibp_pkg::S_BIAS;
      end
      ibp_pkg::S_BIAS: begin
        if (sum_neg) begin
          // direct pointer, no path
          out_vld_d  = 1'b1;
          out_st_d   = ibp_pkg::ST_DIRECT;
          out_blk_d  = '0;
          out_off_d  = mag_q[OFF_W-1:0];
          out_last_d = 1'b1;
          state_d    = ibp_pkg::S_IDLE;
        end else begin
          bn_d    = alu_sum_i;
          state_d = ibp_pkg::S_SEARCH;
        end
      end
      ibp_pkg::S_SEARCH: begin
        lbc_d = lbc_up;
        if (sum_neg) begin
          state_d = ibp_pkg::S_BASE1;
        end else begin
          bn_d = alu_sum_i;
          if (lvl_q == ibp_pkg::LAST_LEVEL) begin
            // beyond triple indirect
            out_vld_d  = 1'b1;
            out_st_d   = ibp_pkg::ST_RANGE;
            out_blk_d  = '0;
            out_off_d  = '0;
            out_last_d = 1'b1;
            state_d    = ibp_pkg::S_IDLE;
          end else begin
            lvl_d = lvl_q + 2'd1;
          end
        end
      end
      ibp_pkg::S_BASE1: begin
        mag_d   = alu_sum_i;
        state_d = ibp_pkg::S_BASE2;
      end
      ibp_pkg::S_BASE2: begin
        metal_d = alu_sum_i;
        state_d = ibp_pkg::S_EMIT0;
      end
      ibp_pkg::S_EMIT0: begin
        // inode entry: offset is the indirection level
        out_vld_d  = 1'b1;
        out_st_d   = ibp_pkg::ST_PATH;
        out_blk_d  = metal_q[BN_W-1:0];
        out_off_d  = OFF_W'(lvl_q);
        out_last_d = metal_hit;
        hold_vld_d = 1'b0;
        rem_d      = lvl_q + 2'd1;
        state_d    = metal_hit ? ibp_pkg::S_IDLE : ibp_pkg::S_LOOP;
      end
      ibp_pkg::S_LOOP: begin
        // send the held entry; last once the chain ends or reaches the target
        if (hold_vld_q) begin
          fin        = (rem_q == '0) || metal_hit;
          out_vld_d  = 1'b1;
          out_st_d   = ibp_pkg::ST_PATH;
          out_blk_d  = hold_blk_q[BN_W-1:0];
          out_off_d  = hold_off_q;
          out_last_d = fin;
        end
        if (fin || (!hold_vld_q && rem_q == '0)) begin
          hold_vld_d = 1'b0;
          state_d    = ibp_pkg::S_IDLE;
        end else if (rem_q != '0) begin
          hold_blk_d = metal_q;
          hold_off_d = off_val;
          hold_vld_d = 1'b1;
          metal_d    = alu_sum_i;
          lbc_d      = lbc_dn;
          rem_d      = rem_q - 2'd1;
        end
      end
      default: state_d = ibp_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ibp_pkg::S_IDLE;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    raw_q      <= raw_d;
    lg_q       <= lg_d;
    mag_q      <= mag_d;
    bn_q       <= bn_d;
    metal_q    <= metal_d;
    lbc_q      <= lbc_d;
    lvl_q      <= lvl_d;
    rem_q      <= rem_d;
    hold_blk_q <= hold_blk_d;
    hold_off_q <= hold_off_d;
    out_st_q   <= out_st_d;
    out_blk_q  <= out_blk_d;
    out_off_q  <= out_off_d;
    out_last_q <= out_last_d;
  end

  assign busy_o       = (state_q != ibp_pkg::S_IDLE);
  assign res_vld_o    = out_vld_q;
  assign res_status_o = out_st_q;
  assign res_blk_o    = out_blk_q;
  assign res_off_o    = out_off_q;
  assign res_last_o   = out_last_q;

endmodule

FILE: src/ibp_checker.sv
// Port-level checks for indirect_block_path, attached by the bind below.
// Depends on ibp_pkg.
module ibp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            result_valid_o,
  input logic [ibp_pkg::ST_W-1:0]        status_o,
  input logic [ibp_pkg::BN_W-1:0]        level_block_o,
  input logic                            last_o
);

  // An accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Results only come from work in progress
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a request in progress");

  // The final result frees the block; earlier ones do not
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (last_o == !busy))
    else $error("last flag and busy disagree");

  // Direct and out-of-range answers are single results with no block
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != ibp_pkg::ST_PATH) |-> (last_o && level_block_o == '0))
    else $error("non-path result not a lone final result");

endmodule

bind indirect_block_path ibp_checker u_ibp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .level_block_o  (level_block_o),
  .last_o         (last_o)
);
